// ----- sv/fpb_pkg.sv -----
// Shared types and constants for the float power-by-squaring block.
// No dependencies; imported by the controller, datapath, FP unit and top level.
package fpb_pkg;

  // IEEE double constants
  localparam logic [63:0] DBL_ONE   = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_DNAN  = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] DBL_QBIT  = 64'h0008_0000_0000_0000;
  localparam logic [10:0] EXP_MAX   = 11'h7FF;

  // FP unit operations
  localparam logic FOP_MUL   = 1'b0;
  localparam logic FOP_RECIP = 1'b1;

  // operand A selects
  localparam logic [1:0] ASEL_SQ  = 2'd0;
  localparam logic [1:0] ASEL_RD  = 2'd1;
  localparam logic [1:0] ASEL_X   = 2'd2;
  localparam logic [1:0] ASEL_ACC = 2'd3;

  // operand B selects
  localparam logic BSEL_SQ  = 1'b0;
  localparam logic BSEL_ACC = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic       load;
    logic       bit_step;
    logic       pop;
    logic       cnt_dec;
    logic       fpu_start;
    logic       fpu_op;
    logic [1:0] a_sel;
    logic       b_sel;
    logic       wr_sq;
    logic       wr_acc;
    logic       out_load;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic mag_zero;
    logic neg;
    logic mag_odd;
    logic n_last;
    logic top_zero;
    logic cnt_zero;
    logic fpu_done;
    logic fpu_busy;
  } sts_t;

endpackage

// ----- sv/fpb_fpu.sv -----
// Multi-cycle IEEE double unit: multiply (one 27x27 multiplier, four partial
// products) and reciprocal (restoring division, one bit per cycle). Uses fpb_pkg.
module fpb_fpu
  import fpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        op,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic        busy,
  output logic [63:0] res
);

  localparam logic [2:0] F_IDLE   = 3'd0;
  localparam logic [2:0] F_NORM   = 3'd1;
  localparam logic [2:0] F_MUL    = 3'd2;
  localparam logic [2:0] F_ALIGN  = 3'd3;
  localparam logic [2:0] F_DIV    = 3'd4;
  localparam logic [2:0] F_DENORM = 3'd5;
  localparam logic [2:0] F_ROUND  = 3'd6;
  localparam logic [2:0] F_DONE   = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic                op_r, op_nxt;
  logic                sign_r, sign_nxt;
  logic [52:0]         sa_r, sa_nxt, sb_r, sb_nxt;
  logic signed [12:0]  ea_r, ea_nxt, eb_r, eb_nxt;
  logic signed [12:0]  be_r, be_nxt;
  logic [105:0]        man_r, man_nxt;
  logic [53:0]         prod_r, prod_nxt;
  logic [53:0]         rem_r, rem_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic [2:0]          ph_r, ph_nxt;
  logic [63:0]         res_r, res_nxt;

  // operand classification
  logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic [52:0] a_sig, b_sig;
  logic signed [12:0] a_exp, b_exp;

  always_comb begin
    a_nan  = (a[62:52] == EXP_MAX) && (a[51:0] != '0);
    a_inf  = (a[62:52] == EXP_MAX) && (a[51:0] == '0);
    a_zero = (a[62:52] == '0) && (a[51:0] == '0);
    b_nan  = (b[62:52] == EXP_MAX) && (b[51:0] != '0);
    b_inf  = (b[62:52] == EXP_MAX) && (b[51:0] == '0);
    b_zero = (b[62:52] == '0) && (b[51:0] == '0);
    a_sig  = {(a[62:52] != '0), a[51:0]};
    b_sig  = {(b[62:52] != '0), b[51:0]};
    a_exp  = (a[62:52] == '0) ? -13'sd1022 : $signed({2'b00, a[62:52]}) - 13'sd1023;
    b_exp  = (b[62:52] == '0) ? -13'sd1022 : $signed({2'b00, b[62:52]}) - 13'sd1023;
  end

  // partial product operand select
  logic [26:0] pm_a, pm_b;
  logic [53:0] pp;
  logic [105:0] pp_shifted;

  always_comb begin
    case (ph_r)
      3'd0:    begin pm_a = sa_r[26:0];         pm_b = sb_r[26:0];         end
      3'd1:    begin pm_a = sa_r[26:0];         pm_b = {1'b0, sb_r[52:27]}; end
      3'd2:    begin pm_a = {1'b0, sa_r[52:27]}; pm_b = sb_r[26:0];         end
      default: begin pm_a = {1'b0, sa_r[52:27]}; pm_b = {1'b0, sb_r[52:27]}; end
    endcase
    pp = 54'(pm_a) * 54'(pm_b);
    // weight of the product registered last cycle (phase ph_r-1)
    case (ph_r)
      3'd1:          pp_shifted = 106'(prod_r);
      3'd2, 3'd3:    pp_shifted = 106'(prod_r) << 27;
      default:       pp_shifted = 106'(prod_r) << 54;
    endcase
  end

  // rounding
  logic [53:0]        r54;
  logic               rnd_inc;
  logic signed [12:0] fld;
  logic [51:0]        frac;

  always_comb begin
    rnd_inc = man_r[52] & ((|man_r[51:0]) | man_r[53]);
    r54     = {1'b0, man_r[105:53]} + 54'(rnd_inc);
    if (r54[53]) begin
      fld  = be_r + 13'sd1;
      frac = '0;
    end else begin
      fld  = r54[52] ? be_r : 13'sd0;
      frac = r54[51:0];
    end
  end

  logic       ge;
  logic [53:0] rem_sub;

  always_comb begin
    ge      = rem_r >= {1'b0, sa_r};
    rem_sub = ge ? rem_r - {1'b0, sa_r} : rem_r;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    sign_nxt  = sign_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    ea_nxt    = ea_r;
    eb_nxt    = eb_r;
    be_nxt    = be_r;
    man_nxt   = man_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    ph_nxt    = ph_r;
    res_nxt   = res_r;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          op_nxt = op;
          sa_nxt = a_sig;
          sb_nxt = b_sig;
          ea_nxt = a_exp;
          eb_nxt = b_exp;
          state_nxt = F_DONE;
          if (op == FOP_MUL) begin
            sign_nxt = a[63] ^ b[63];
            if (a_nan)                                   res_nxt = a | DBL_QBIT;
            else if (b_nan)                              res_nxt = b | DBL_QBIT;
            else if ((a_inf && b_zero) || (a_zero && b_inf)) res_nxt = DBL_DNAN;
            else if (a_inf || b_inf)    res_nxt = {a[63] ^ b[63], EXP_MAX, 52'd0};
            else if (a_zero || b_zero)  res_nxt = {a[63] ^ b[63], 63'd0};
            else                        state_nxt = F_NORM;
          end else begin
            sign_nxt = a[63];
            if (a_nan)       res_nxt = a | DBL_QBIT;
            else if (a_inf)  res_nxt = {a[63], 63'd0};
            else if (a_zero) res_nxt = {a[63], EXP_MAX, 52'd0};
            else             state_nxt = F_NORM;
          end
        end
      end
      // bring subnormal significands up to a leading one, a bit per cycle
      F_NORM: begin
        if (!sa_r[52]) begin
          sa_nxt = {sa_r[51:0], 1'b0};
          ea_nxt = ea_r - 13'sd1;
        end else if (op_r == FOP_MUL && !sb_r[52]) begin
          sb_nxt = {sb_r[51:0], 1'b0};
          eb_nxt = eb_r - 13'sd1;
        end else if (op_r == FOP_MUL) begin
          man_nxt   = '0;
          ph_nxt    = '0;
          state_nxt = F_MUL;
        end else begin
          cnt_nxt = '0;
          man_nxt = '0;
          // dividend 1.0, or 2.0 when the quotient would fall below one
          if (sa_r[51:0] == '0) begin
            rem_nxt = 54'(sa_r);
            be_nxt  = 13'sd1023 - ea_r;
          end else begin
            rem_nxt = {1'b1, 53'd0};
            be_nxt  = 13'sd1022 - ea_r;
          end
          state_nxt = F_DIV;
        end
      end
      // four partial products, each accumulated in the cycle after it is formed
      F_MUL: begin
        if (ph_r < 3'd4) prod_nxt = pp;
        if (ph_r != 3'd0) man_nxt = man_r + pp_shifted;
        ph_nxt = ph_r + 3'd1;
        if (ph_r == 3'd4) state_nxt = F_ALIGN;
      end
      F_ALIGN: begin
        be_nxt = ea_r + eb_r + 13'sd1023 + (man_r[105] ? 13'sd1 : 13'sd0);
        if (!man_r[105]) man_nxt = {man_r[104:0], 1'b0};
        state_nxt = F_DENORM;
      end
      // restoring division of 1.0 or 2.0 by the significand, 56 quotient bits
      F_DIV: begin
        if (cnt_r == 6'd56) begin
          man_nxt   = {man_r[55:0], 49'd0, (rem_r != '0)};
          state_nxt = F_DENORM;
        end else begin
          man_nxt = {man_r[104:0], ge};
          rem_nxt = {rem_sub[52:0], 1'b0};
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      // shift right into the subnormal range, keeping a sticky bit
      F_DENORM: begin
        if (be_r < -13'sd60) begin
          man_nxt = {105'd0, |man_r};
          be_nxt  = 13'sd1;
        end else if (be_r < 13'sd1) begin
          man_nxt = {1'b0, man_r[105:2], man_r[1] | man_r[0]};
          be_nxt  = be_r + 13'sd1;
        end else begin
          state_nxt = F_ROUND;
        end
      end
      F_ROUND: begin
        if (fld >= 13'sd2047) res_nxt = {sign_r, EXP_MAX, 52'd0};
        else                  res_nxt = {sign_r, fld[10:0], frac};
        state_nxt = F_DONE;
      end
      F_DONE: begin
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r   <= op_nxt;
    sign_r <= sign_nxt;
    sa_r   <= sa_nxt;
    sb_r   <= sb_nxt;
    ea_r   <= ea_nxt;
    eb_r   <= eb_nxt;
    be_r   <= be_nxt;
    man_r  <= man_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    ph_r   <= ph_nxt;
    res_r  <= res_nxt;
  end

  assign done = (state_r == F_DONE);
  assign busy = (state_r != F_IDLE);
  assign res  = res_r;

endmodule

// ----- sv/fpb_datapath.sv -----
// Datapath: input latch, square register, exponent shifter, square stack,
// running product and output register around one fpb_fpu. Uses fpb_pkg.
module fpb_datapath
  import fpb_pkg::*;
#(
  parameter int EXP_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [63:0]        in_base_bits,
  input  logic signed [15:0] in_exponent,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic [63:0]        out_power_bits
);

  localparam int IDX_W = $clog2(EXP_BITS);
  localparam int TOP_W = $clog2(EXP_BITS + 1);

  logic [EXP_BITS-1:0] raw, mag_in;
  logic [EXP_BITS-1:0] mag_r, n_r, cnt_r;
  logic                neg_r;
  logic [63:0]         x_r, sq_r, acc_r, rd_r, out_r;
  logic [TOP_W-1:0]    top_r;
  logic [TOP_W-1:0]    top_m1;
  logic [63:0]         stack_mem [EXP_BITS];

  logic [63:0] fa, fb, fres;
  logic        fdone, fbusy;

  // exponent magnitude from the low EXP_BITS bits
  assign raw    = EXP_BITS'($unsigned(in_exponent));
  assign mag_in = raw[EXP_BITS-1] ? (~raw + EXP_BITS'(1)) : raw;
  assign top_m1 = top_r - TOP_W'(1);

  always_comb begin
    case (cmd.a_sel)
      ASEL_SQ:  fa = sq_r;
      ASEL_RD:  fa = rd_r;
      ASEL_X:   fa = x_r;
      default:  fa = acc_r;
    endcase
    fb = (cmd.b_sel == BSEL_SQ) ? sq_r : acc_r;
  end

  fpb_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.fpu_start),
    .op    (cmd.fpu_op),
    .a     (fa),
    .b     (fb),
    .done  (fdone),
    .busy  (fbusy),
    .res   (fres)
  );

  // stack position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
    end else if (cmd.load) begin
      top_r <= '0;
    end else if (cmd.bit_step && n_r[0]) begin
      top_r <= top_r + TOP_W'(1);
    end else if (cmd.pop) begin
      top_r <= top_m1;
    end
  end

  // square stack, registered read
  always_ff @(posedge clk) begin
    if (cmd.bit_step && n_r[0]) stack_mem[top_r[IDX_W-1:0]] <= sq_r;
    if (cmd.pop) rd_r <= stack_mem[top_m1[IDX_W-1:0]];
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= in_base_bits;
      sq_r  <= in_base_bits;
      mag_r <= mag_in;
      neg_r <= raw[EXP_BITS-1];
      n_r   <= mag_in;
      cnt_r <= mag_in + EXP_BITS'(mag_in[0]);
      acc_r <= DBL_ONE;
    end else begin
      if (cmd.bit_step) n_r <= n_r >> 1;
      if (cmd.cnt_dec)  cnt_r <= cnt_r - EXP_BITS'(1);
      if (cmd.wr_sq && fdone)  sq_r  <= fres;
      if (cmd.wr_acc && fdone) acc_r <= fres;
    end
    if (cmd.out_load) out_r <= acc_r;
  end

  always_comb begin
    sts.mag_zero = (mag_r == '0);
    sts.neg      = neg_r;
    sts.mag_odd  = mag_r[0];
    sts.n_last   = ((n_r >> 1) == '0);
    sts.top_zero = (top_r == '0);
    sts.cnt_zero = (cnt_r == '0);
    sts.fpu_done = fdone;
    sts.fpu_busy = fbusy;
  end

  assign out_power_bits = out_r;

endmodule

// ----- sv/fpb_ctrl.sv -----
// Controller state machine: sequences squaring, stack unwind, linear product,
// reciprocal, odd-exponent multiply and the output beat. Uses fpb_pkg command and status structs.
module fpb_ctrl
  import fpb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SQ_STEP  = 4'd2;
  localparam logic [3:0] S_SQ_WAIT  = 4'd3;
  localparam logic [3:0] S_POP      = 4'd4;
  localparam logic [3:0] S_UN_MUL   = 4'd5;
  localparam logic [3:0] S_UN_WAIT  = 4'd6;
  localparam logic [3:0] S_LIN      = 4'd7;
  localparam logic [3:0] S_LIN_WAIT = 4'd8;
  localparam logic [3:0] S_RC_WAIT  = 4'd9;
  localparam logic [3:0] S_ODD      = 4'd10;
  localparam logic [3:0] S_ODD_WAIT = 4'd11;
  localparam logic [3:0] S_FIN      = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.a_sel = ASEL_ACC;
    cmd.b_sel = BSEL_ACC;
    cmd.fpu_op = FOP_MUL;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.mag_zero)  state_nxt = S_FIN;
        else if (!sts.neg) state_nxt = S_SQ_STEP;
        else               state_nxt = S_LIN;
      end
      // push square for a set bit, square again while bits remain
      S_SQ_STEP: begin
        cmd.bit_step = 1'b1;
        if (sts.n_last) begin
          state_nxt = S_POP;
        end else begin
          cmd.fpu_start = 1'b1;
          cmd.a_sel     = ASEL_SQ;
          cmd.b_sel     = BSEL_SQ;
          state_nxt     = S_SQ_WAIT;
        end
      end
      S_SQ_WAIT: begin
        cmd.wr_sq = 1'b1;
        if (sts.fpu_done) state_nxt = S_SQ_STEP;
      end
      // multiply stacked squares, highest first, into the product
      S_POP: begin
        if (sts.top_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_UN_MUL;
        end
      end
      S_UN_MUL: begin
        cmd.fpu_start = 1'b1;
        cmd.a_sel     = ASEL_RD;
        state_nxt     = S_UN_WAIT;
      end
      S_UN_WAIT: begin
        cmd.wr_acc = 1'b1;
        if (sts.fpu_done) state_nxt = S_POP;
      end
      // linear product, then reciprocal
      S_LIN: begin
        cmd.fpu_start = 1'b1;
        if (sts.cnt_zero) begin
          cmd.fpu_op = FOP_RECIP;
          state_nxt  = S_RC_WAIT;
        end else begin
          cmd.a_sel   = ASEL_X;
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_LIN_WAIT;
        end
      end
      S_LIN_WAIT: begin
        cmd.wr_acc = 1'b1;
        if (sts.fpu_done) state_nxt = S_LIN;
      end
      S_RC_WAIT: begin
        cmd.wr_acc = 1'b1;
        if (sts.fpu_done) state_nxt = sts.mag_odd ? S_ODD : S_FIN;
      end
      S_ODD: begin
        cmd.fpu_start = 1'b1;
        cmd.a_sel     = ASEL_X;
        state_nxt     = S_ODD_WAIT;
      end
      S_ODD_WAIT: begin
        cmd.wr_acc = 1'b1;
        if (sts.fpu_done) state_nxt = S_FIN;
      end
      // hand off to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load)              out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- sv/float_power_by_squaring.sv -----
// Top level of the float power-by-squaring block: controller plus datapath.
// Depends on fpb_pkg, fpb_ctrl, fpb_datapath (and fpb_fpu below it).
//
// Raises an IEEE double base to a signed integer exponent (low EXP_BITS bits
// of in_exponent, two's complement) with round-to-nearest-even, one result
// beat per input beat. One item is in work at a time; the next input beat is
// taken as soon as the result sits in the output register. The multiplies and
// the reciprocal all run on the single shared FP unit; a multiply takes longer
// for each leading zero of a subnormal operand and each bit of subnormal
// output shift. A positive exponent needs about 2*log2(ex) multiplies; a
// negative exponent needs |ex| (+2 if odd) multiplies plus one reciprocal;
// a zero exponent needs none.
module float_power_by_squaring
  import fpb_pkg::*;
#(
  parameter int EXP_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        in_base_bits,
  input  logic signed [15:0] in_exponent,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        out_power_bits
);

  cmd_t cmd;
  sts_t sts;

  fpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpb_datapath #(
    .EXP_BITS (EXP_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_base_bits   (in_base_bits),
    .in_exponent    (in_exponent),
    .cmd            (cmd),
    .sts            (sts),
    .out_power_bits (out_power_bits)
  );

  // FP unit is started only when free
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fpu_start |-> !sts.fpu_busy)
    else $error("fpu started while busy");

  // result only loaded into a free or draining output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten");

  // a loaded result shows up as a valid beat
  a_out_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  // no new input beat while an item is in work
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fpu_start |-> in_stall)
    else $error("input accepted during work");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for float_power_by_squaring: directed rows, then random beats.
// Depends on fpb_pkg and the float_power_by_squaring RTL; results are checked against
// typed row values or an in-bench IEEE double power predictor.
module testbench
  import fpb_pkg::*;
();

  localparam int NUM_RANDOM = 600;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [63:0]        in_base_bits = '0;
  logic signed [15:0] in_exponent = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [63:0]        out_power_bits;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          errors = 0;
  logic [63:0] power_queue[$];

  typedef struct {
    logic [63:0]        base;
    logic signed [15:0] expo;
    bit                 typed;
    logic [63:0]        power;
  } row_t;

  float_power_by_squaring dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_base_bits(in_base_bits), .in_exponent(in_exponent),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_power_bits(out_power_bits)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------- double arithmetic predictor ----------------
  function automatic bit is_nan(input logic [63:0] v);
    return (v[62:52] == EXP_MAX) && (v[51:0] != '0);
  endfunction

  // NaN operands propagate quieted, first operand first; invalid gives default NaN
  function automatic logic [63:0] dbl_mul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    if (is_nan(a)) return a | DBL_QBIT;
    if (is_nan(b)) return b | DBL_QBIT;
    p = $realtobits($bitstoreal(a) * $bitstoreal(b));
    if (is_nan(p)) return DBL_DNAN;
    return p;
  endfunction

  function automatic logic [63:0] dbl_recip(input logic [63:0] r);
    if (is_nan(r)) return r | DBL_QBIT;
    // reciprocal of a signed zero: infinity of the same sign
    if (r[62:0] == '0) return {r[63], EXP_MAX, 52'h0};
    return $realtobits(1.0 / $bitstoreal(r));
  endfunction

  function automatic logic [63:0] chain_product(input logic [63:0] x, input int unsigned n);
    logic [63:0] r;
    r = DBL_ONE;
    for (int unsigned i = 0; i < n; i++) r = dbl_mul(x, r);
    return r;
  endfunction

  function automatic logic [63:0] predict_power(input logic [63:0] x,
                                                input logic signed [15:0] e);
    logic [63:0]  squares[16];
    logic [63:0]  sq;
    logic [63:0]  r;
    logic [16:0]  mag;
    int unsigned  top;
    mag = e[15] ? (~{1'b1, e} + 17'd1) : {1'b0, e};
    if (mag == 0) return DBL_ONE;
    if (!e[15]) begin
      // square up, keep squares of set bits, then fold from the top down
      sq = x;
      top = 0;
      while (mag != 0 && top < 16) begin
        if (mag[0]) begin
          squares[top] = sq;
          top++;
        end
        mag = mag >> 1;
        if (mag != 0) sq = dbl_mul(sq, sq);
      end
      r = DBL_ONE;
      while (top > 0) begin
        top--;
        r = dbl_mul(squares[top], r);
      end
      return r;
    end
    if (!mag[0]) return dbl_recip(chain_product(x, mag));
    return dbl_mul(x, dbl_recip(chain_product(x, mag + 1)));
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [63:0] rand_base();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: v = {v[63], 63'h0};                        // signed zero
      1: v = {v[63], EXP_MAX, 52'h0};               // infinity
      2: v = {v[63], EXP_MAX, v[51:0] | 52'h1};      // NaN
      3: v = {v[63], 11'h000, v[51:0]};             // subnormal
      4, 5, 6: v = {v[63], $urandom_range(1) ? 11'h3FF : 11'h3FE, v[51:0]};
      default: ;                                    // any pattern
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] rand_exponent();
    case ($urandom_range(9))
      0: return 16'sd0;
      1, 2, 3, 4: return 16'($urandom_range(32767, 1));
      5, 6, 7: return -16'($urandom_range(64, 1));
      8: return -16'($urandom_range(600, 65));
      default: return 16'($urandom_range(20, 1));
    endcase
  endfunction

  // present one beat, hold it until accepted, record its expected power
  task automatic send_beat(input logic [63:0] b, input logic signed [15:0] e,
                           input bit typed, input logic [63:0] power);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_base_bits <= b;
    in_exponent  <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    power_queue.push_back(typed ? power : predict_power(b, e));
  endtask

  // receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (power_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_power_bits);
        errors++;
      end else begin
        logic [63:0] want;
        want = power_queue.pop_front();
        if (out_power_bits !== want) begin
          $display("%0t: power_bits mismatch, expected %h, actual %h",
                   $time, want, out_power_bits);
          errors++;
        end
      end
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    row_t rows[$];
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    int unsigned guard;
    idle_tab  = '{0, 81, 0, 22};
    stall_tab = '{0, 0, 81, 22};

    rows = '{
      '{DBL_ONE,               16'sd0,      1'b1, DBL_ONE},
      '{64'h7FF8_0000_0000_0001, 16'sd0,    1'b1, DBL_ONE},
      '{64'h4000_0000_0000_0000, 16'sd10,   1'b1, 64'h4090_0000_0000_0000},
      '{64'h3FE0_0000_0000_0000, -16'sd1,   1'b1, 64'h4000_0000_0000_0000},
      '{64'h0,                 -16'sd1,     1'b1, DBL_DNAN},
      '{64'h8000_0000_0000_0000, -16'sd2,   1'b1, 64'h7FF0_0000_0000_0000},
      '{64'h7FF0_0000_0000_0000, -16'sd2,   1'b1, 64'h0},
      '{64'h7FF0_0000_0000_0000, -16'sd1,   1'b1, DBL_DNAN},
      '{64'h4008_0000_0000_0000, -16'sd32768, 1'b1, 64'h0},
      '{64'h7FEF_FFFF_FFFF_FFFF, 16'sd32767, 1'b0, '0},
      '{64'hFFEF_FFFF_FFFF_FFFF, 16'sd3,    1'b0, '0},
      '{64'h0000_0000_0000_0001, 16'sd2,    1'b0, '0},
      '{64'h8000_0000_0000_0001, -16'sd3,   1'b0, '0},
      '{64'h7FF0_0000_0000_0001, 16'sd3,    1'b0, '0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 16'sd1,    1'b0, '0},
      '{64'hC000_0000_0000_0000, -16'sd3,   1'b0, '0},
      '{64'h3FF8_0000_0000_0000, 16'sd32767, 1'b0, '0},
      '{64'h3FF0_0000_0000_0001, 16'sd16384, 1'b0, '0},
      '{64'hBFEF_FFFF_FFFF_FFFF, -16'sd63,  1'b0, '0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_beat(rows[i].base, rows[i].expo, rows[i].typed, rows[i].power);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_tab[p];
      recv_stall_pct = stall_tab[p];
      for (int i = 0; i < NUM_RANDOM / 4; i++) send_beat(rand_base(), rand_exponent(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain, then a short tail for stray results
    guard = 0;
    while (power_queue.size() != 0 && guard < 2_000_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);

    if (errors == 0 && power_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/fpb_pkg.sv
sv/fpb_fpu.sv
sv/fpb_datapath.sv
sv/fpb_ctrl.sv
sv/float_power_by_squaring.sv
verif/testbench.sv
